// ===== rtl/extended_gcd_bezout_assert.svh =====
// Assertion macros for the extended GCD block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef EXTENDED_GCD_BEZOUT_ASSERT_SVH
`define EXTENDED_GCD_BEZOUT_ASSERT_SVH

// property that must hold at every edge outside reset
`define EGCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define EGCD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/egcd_pkg.sv =====
// Shared constants, control word types and microcode ROM for the extended GCD block.
// No dependencies.
package egcd_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int CW = OPERAND_WIDTH + 1;
	localparam int CNT_W = $clog2(OPERAND_WIDTH);
	localparam int UPC_W = 3;

	// jump conditions
	localparam logic [2:0] C_NEXT     = 3'd0;
	localparam logic [2:0] C_ALWAYS   = 3'd1;
	localparam logic [2:0] C_NO_IN    = 3'd2;
	localparam logic [2:0] C_R1_ZERO  = 3'd3;
	localparam logic [2:0] C_DIV_MORE = 3'd4;
	localparam logic [2:0] C_OUT_BUSY = 3'd5;

	// program steps
	localparam logic [UPC_W-1:0] STEP_WAIT = 3'd0;
	localparam logic [UPC_W-1:0] STEP_TEST = 3'd1;
	localparam logic [UPC_W-1:0] STEP_DIV  = 3'd2;
	localparam logic [UPC_W-1:0] STEP_MULS = 3'd3;
	localparam logic [UPC_W-1:0] STEP_UPDS = 3'd4;
	localparam logic [UPC_W-1:0] STEP_UPDT = 3'd5;
	localparam logic [UPC_W-1:0] STEP_SPARE = 3'd6;
	localparam logic [UPC_W-1:0] STEP_DONE = 3'd7;

	typedef struct packed {
		logic             in_rdy;
		logic             ld_in;
		logic             div_init;
		logic             div_step;
		logic             mul_en;
		logic             mul_t;
		logic             upd_s;
		logic             upd_t;
		logic             adv_r;
		logic             out_ld;
		logic [2:0]       cond;
		logic [UPC_W-1:0] target;
	} egcd_ctrl_t;

	typedef struct packed {
		logic r1_zero;
		logic div_last;
		logic out_busy;
	} egcd_stat_t;

	function automatic egcd_ctrl_t urom(input logic [UPC_W-1:0] step);
		egcd_ctrl_t w;
		w = '0;
		case (step)
			STEP_WAIT: begin
				w.in_rdy = 1'b1;
				w.ld_in  = 1'b1;
				w.cond   = C_NO_IN;
				w.target = STEP_WAIT;
			end
			STEP_TEST: begin
				w.div_init = 1'b1;
				w.cond     = C_R1_ZERO;
				w.target   = STEP_DONE;
			end
			STEP_DIV: begin
				w.div_step = 1'b1;
				w.cond     = C_DIV_MORE;
				w.target   = STEP_DIV;
			end
			STEP_MULS: begin
				w.mul_en = 1'b1;
			end
			STEP_UPDS: begin
				w.upd_s  = 1'b1;
				w.mul_en = 1'b1;
				w.mul_t  = 1'b1;
			end
			STEP_UPDT: begin
				w.upd_t  = 1'b1;
				w.adv_r  = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = STEP_TEST;
			end
			STEP_DONE: begin
				// falls through to STEP_WAIT by wraparound
				w.out_ld = 1'b1;
				w.cond   = C_OUT_BUSY;
				w.target = STEP_DONE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/egcd_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on egcd_pkg.
module egcd_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  egcd_pkg::egcd_stat_t        stat,
	output egcd_pkg::egcd_ctrl_t        ctrl,
	output logic [egcd_pkg::UPC_W-1:0]  upc
);

	logic [egcd_pkg::UPC_W-1:0] upc_q;
	egcd_pkg::egcd_ctrl_t       word;
	logic                       take;

	always_comb begin
		word = egcd_pkg::urom(upc_q);
		case (word.cond)
			egcd_pkg::C_NEXT:     take = 1'b0;
			egcd_pkg::C_ALWAYS:   take = 1'b1;
			egcd_pkg::C_NO_IN:    take = !in_valid;
			egcd_pkg::C_R1_ZERO:  take = stat.r1_zero;
			egcd_pkg::C_DIV_MORE: take = !stat.div_last;
			egcd_pkg::C_OUT_BUSY: take = stat.out_busy;
			default:              take = 1'b1;
		endcase
		ctrl = word;
		ctrl.ld_in  = word.ld_in && in_valid;
		ctrl.out_ld = word.out_ld && !stat.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= egcd_pkg::STEP_WAIT;
		end else if (take) begin
			upc_q <= word.target;
		end else begin
			upc_q <= upc_q + egcd_pkg::UPC_W'(1);
		end
	end

	assign upc = upc_q;

endmodule

// ===== rtl/egcd_dp.sv =====
// Datapath: remainder and coefficient registers, restoring divider,
// multiply-subtract and output register. Depends on egcd_pkg.
module egcd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  egcd_pkg::egcd_ctrl_t                ctrl,
	output egcd_pkg::egcd_stat_t                stat,
	input  logic [egcd_pkg::OPERAND_WIDTH-1:0]  op_a,
	input  logic [egcd_pkg::OPERAND_WIDTH-1:0]  op_b,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [egcd_pkg::OPERAND_WIDTH-1:0]  divisor,
	output logic signed [egcd_pkg::CW-1:0]      coef_a,
	output logic signed [egcd_pkg::CW-1:0]      coef_b
);

	localparam int W  = egcd_pkg::OPERAND_WIDTH;
	localparam int CW = egcd_pkg::CW;

	logic [W-1:0]                 r0_q, r1_q, dq_q, rem_q;
	logic [CW-1:0]                s0_q, s1_q, t0_q, t1_q, prod_q;
	logic [egcd_pkg::CNT_W-1:0]   cnt_q;
	logic [W-1:0]                 div_q;
	logic [CW-1:0]                coa_q, cob_q;
	logic                         out_valid_q;

	logic [W:0]                   shifted, r1_ext, diff;
	logic                         ge;
	logic [W-1:0]                 rem_n;
	logic [CW-1:0]                mul_src;
	logic [2*CW-1:0]              prod_full;

	always_comb begin
		shifted = {rem_q, dq_q[W-1]};
		r1_ext  = {1'b0, r1_q};
		diff    = shifted - r1_ext;
		ge      = shifted >= r1_ext;
		rem_n   = ge ? diff[W-1:0] : shifted[W-1:0];
		mul_src = ctrl.mul_t ? t1_q : s1_q;
		prod_full = {{(CW+1){1'b0}}, dq_q} * {{CW{1'b0}}, mul_src};
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_in) begin
			r0_q <= op_a;
			r1_q <= op_b;
			s0_q <= CW'(1);
			s1_q <= '0;
			t0_q <= '0;
			t1_q <= CW'(1);
		end
		if (ctrl.div_init) begin
			dq_q  <= r0_q;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (ctrl.div_step) begin
			rem_q <= rem_n;
			dq_q  <= {dq_q[W-2:0], ge};
			cnt_q <= cnt_q + egcd_pkg::CNT_W'(1);
		end
		if (ctrl.mul_en) begin
			prod_q <= prod_full[CW-1:0];
		end
		if (ctrl.upd_s) begin
			s0_q <= s1_q;
			s1_q <= s0_q - prod_q;
		end
		if (ctrl.upd_t) begin
			t0_q <= t1_q;
			t1_q <= t0_q - prod_q;
		end
		if (ctrl.adv_r) begin
			r0_q <= r1_q;
			r1_q <= rem_q;
		end
		if (ctrl.out_ld) begin
			div_q <= r0_q;
			coa_q <= s0_q;
			cob_q <= t0_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.r1_zero  = (r1_q == '0);
	assign stat.div_last = (cnt_q == egcd_pkg::CNT_W'(W - 1));
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign divisor   = div_q;
	assign coef_a    = coa_q;
	assign coef_b    = cob_q;

endmodule

// ===== rtl/extended_gcd_bezout.sv =====
// Extended GCD with Bezout coefficients: top level, sequencer plus datapath.
// Depends on egcd_pkg, egcd_seq, egcd_dp and extended_gcd_bezout_assert.svh.
// Each Euclid step runs the restoring divider (one quotient bit per cycle) and then
// three multiply-subtract steps: MULS, UPDS and UPDT.
// Throughput: one item at a time; a new beat is taken once the result is in the output register.
// Reset: arst_n clears the step counter and output valid; data registers are not reset.
module extended_gcd_bezout (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [egcd_pkg::OPERAND_WIDTH-1:0]  op_a,
	input  logic [egcd_pkg::OPERAND_WIDTH-1:0]  op_b,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [egcd_pkg::OPERAND_WIDTH-1:0]  divisor,
	output logic signed [egcd_pkg::CW-1:0]      coef_a,
	output logic signed [egcd_pkg::CW-1:0]      coef_b
);

	egcd_pkg::egcd_ctrl_t       ctrl;
	egcd_pkg::egcd_stat_t       stat;
	logic [egcd_pkg::UPC_W-1:0] upc;

	egcd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl),
		.upc      (upc)
	);

	egcd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.op_a      (op_a),
		.op_b      (op_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.divisor   (divisor),
		.coef_a    (coef_a),
		.coef_b    (coef_b)
	);

	assign in_ready = ctrl.in_rdy;

`include "extended_gcd_bezout_assert.svh"

	`EGCD_ASSERT(a_accept_to_test, (in_valid && in_ready) |=> (upc == egcd_pkg::STEP_TEST), "accepted beat did not start the program")
	`EGCD_ASSERT(a_out_from_done, $rose(out_valid) |-> $past(upc == egcd_pkg::STEP_DONE), "result raised outside the done step")
	`EGCD_NEVER(a_div_by_zero, ctrl.div_step && stat.r1_zero, "divide step with zero divisor")

endmodule
